[rtl/core/fcma_pkg.sv]
// ----------------------------------------------------------------------------
// fcma_pkg
// Shared types and constants of the file chunk map allocator.
// ----------------------------------------------------------------------------
package fcma_pkg;

  // Geometry of the chunk store and of one file's map.
  localparam int unsigned ChunkCount     = 256;
  localparam int unsigned ChunkW         = 8;
  localparam int unsigned ChunkBytesLog2 = 12;
  localparam int unsigned DirectSlots    = 8;
  localparam int unsigned Fanout         = 4;
  localparam int unsigned FileCount      = 4;
  localparam int unsigned SingleEnd      = DirectSlots + Fanout;
  localparam int unsigned DoubleEnd      = SingleEnd + Fanout * Fanout;
  localparam int unsigned SlotsPerFile   = DoubleEnd + Fanout * Fanout * Fanout;
  localparam int unsigned TotalSlots     = FileCount * SlotsPerFile;
  localparam int unsigned SlotAw         = $clog2(TotalSlots);
  localparam int unsigned LocalW         = $clog2(SlotsPerFile + 1);
  localparam int unsigned PageW          = 32 - ChunkBytesLog2;

  // The chunk bitmap is searched as groups of sixteen chunks.
  localparam int unsigned GroupBits      = 16;
  localparam int unsigned GroupCount     = ChunkCount / GroupBits;
  localparam int unsigned GroupW         = $clog2(GroupCount);
  localparam int unsigned GroupIdxW      = $clog2(GroupBits);

  // Operation codes on the input word.
  localparam logic [1:0] OpRead    = 2'd0;
  localparam logic [1:0] OpWrite   = 2'd1;
  localparam logic [1:0] OpRelease = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    StHit      = 3'd0,
    StAlloc    = 3'd1,
    StUnmapped = 3'd2,
    StNoFree   = 3'd3,
    StTooLarge = 3'd4,
    StReleased = 3'd5
  } status_e;

  // Classified work kinds passed from the front to the back.
  typedef enum logic [1:0] {
    KindRead     = 2'd0,
    KindWrite    = 2'd1,
    KindRelease  = 2'd2,
    KindTooLarge = 2'd3
  } kind_e;

  // One queued job.
  typedef struct packed {
    kind_e                     kind;
    logic [SlotAw-1:0]         addr;   // slot address, or file base for release
    logic [ChunkBytesLog2-1:0] inner;
    logic [1:0]                level;
  } job_t;

endpackage

[rtl/core/fcma_front.sv]
// ----------------------------------------------------------------------------
// fcma_front
// Accepts input words, finds the map region and slot address, and queues
// a classified job for the back end.
// ----------------------------------------------------------------------------
module fcma_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [1:0]          file_index_i,
  input  logic [31:0]         byte_offset_i,
  input  logic                hold_i,
  output logic                push_o,
  output fcma_pkg::job_t      job_o
);

  logic [fcma_pkg::PageW-1:0]  page;
  logic [fcma_pkg::SlotAw-1:0] base;
  logic                        full_q;

  // The queue reports back through hold_i; full_q only latches reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b1;
    end else begin
      full_q <= 1'b0;
    end
  end

  assign in_stall_o = hold_i | full_q;
  assign push_o     = in_valid_i & ~in_stall_o;

  // Classify the offset into a region and a flat slot address.
  always_comb begin
    page       = byte_offset_i[31:fcma_pkg::ChunkBytesLog2];
    base       = fcma_pkg::SlotAw'(file_index_i) *
                 fcma_pkg::SlotAw'(fcma_pkg::SlotsPerFile);
    job_o.inner = byte_offset_i[fcma_pkg::ChunkBytesLog2-1:0];
    job_o.addr  = base + fcma_pkg::SlotAw'(page[fcma_pkg::LocalW-1:0]);
    if (page < fcma_pkg::PageW'(fcma_pkg::DirectSlots)) begin
      job_o.level = 2'd0;
    end else if (page < fcma_pkg::PageW'(fcma_pkg::SingleEnd)) begin
      job_o.level = 2'd1;
    end else if (page < fcma_pkg::PageW'(fcma_pkg::DoubleEnd)) begin
      job_o.level = 2'd2;
    end else begin
      job_o.level = 2'd3;
    end
    if (operation_i == fcma_pkg::OpRelease) begin
      job_o.kind  = fcma_pkg::KindRelease;
      job_o.addr  = base;
    end else if (page >= fcma_pkg::PageW'(fcma_pkg::SlotsPerFile)) begin
      job_o.kind  = fcma_pkg::KindTooLarge;
    end else if (operation_i == fcma_pkg::OpWrite) begin
      job_o.kind  = fcma_pkg::KindWrite;
    end else begin
      job_o.kind  = fcma_pkg::KindRead;
    end
  end

endmodule

[rtl/core/fcma_queue.sv]
// ----------------------------------------------------------------------------
// fcma_queue
// Two-entry job queue between the front and the back end.
// ----------------------------------------------------------------------------
module fcma_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fcma_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output fcma_pkg::job_t job_o
);

  fcma_pkg::job_t slot_q [2];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = slot_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_job_i;
    end
  end

endmodule

[rtl/core/fcma_back.sv]
// ----------------------------------------------------------------------------
// fcma_back
// Executes queued jobs against the slot memory and the chunk bitmap, and
// holds the result word until it is taken.
// ----------------------------------------------------------------------------
module fcma_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  fcma_pkg::job_t      q_job_i,
  output logic                q_pop_o,
  output logic                clearing_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic [7:0]          chunk_id_o,
  output logic [11:0]         offset_in_chunk_o,
  output logic [1:0]          map_level_o,
  output logic [6:0]          released_count_o
);

  typedef enum logic [4:0] {
    SClear = 5'b00001,
    SIdle  = 5'b00010,
    SLook  = 5'b00100,
    SAlloc = 5'b01000,
    SRel   = 5'b10000
  } state_e;

  localparam int unsigned MemW = fcma_pkg::ChunkW + 1;

  state_e                          state_q, state_d;
  fcma_pkg::job_t                  cur_q, cur_d;
  logic [fcma_pkg::SlotAw-1:0]     clr_q, clr_d;
  logic [fcma_pkg::LocalW-1:0]     rel_idx_q, rel_idx_d;
  logic                            rel_pend_q, rel_pend_d;
  logic [fcma_pkg::SlotAw-1:0]     rel_addr_q, rel_addr_d;
  logic [6:0]                      rel_cnt_q, rel_cnt_d;
  logic [fcma_pkg::GroupW-1:0]     grp_q, grp_d;
  logic [fcma_pkg::ChunkCount-1:0] used_q, used_d;

  logic                            out_valid_q, out_valid_d;
  logic [2:0]                      status_q, status_d;
  logic [7:0]                      chunk_q, chunk_d;
  logic [11:0]                     inner_q, inner_d;
  logic [1:0]                      level_q, level_d;
  logic [6:0]                      count_q, count_d;

  logic [MemW-1:0]                 mem [fcma_pkg::TotalSlots];
  logic [MemW-1:0]                 rd_q;
  logic                            mem_we, mem_re;
  logic [fcma_pkg::SlotAw-1:0]     mem_wa, mem_ra;
  logic [MemW-1:0]                 mem_wd;

  logic [fcma_pkg::GroupCount-1:0] grp_free;
  logic [fcma_pkg::GroupW-1:0]     grp_first;
  logic [fcma_pkg::GroupBits-1:0]  grp_bits;
  logic [fcma_pkg::GroupIdxW-1:0]  bit_first;
  logic [fcma_pkg::ChunkW-1:0]     new_chunk;

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // Free-group summary and lowest free group.
  always_comb begin
    grp_first = '0;
    for (int g = 0; g < fcma_pkg::GroupCount; g++) begin
      grp_free[g] = ~&used_q[g*fcma_pkg::GroupBits +: fcma_pkg::GroupBits];
    end
    for (int g = fcma_pkg::GroupCount - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        grp_first = fcma_pkg::GroupW'(g);
      end
    end
  end

  // Lowest free chunk inside the chosen group.
  always_comb begin
    grp_bits  = used_q[{grp_q, {fcma_pkg::GroupIdxW{1'b0}}} +: fcma_pkg::GroupBits];
    bit_first = '0;
    for (int b = fcma_pkg::GroupBits - 1; b >= 0; b--) begin
      if (!grp_bits[b]) begin
        bit_first = fcma_pkg::GroupIdxW'(b);
      end
    end
    new_chunk = {grp_q, bit_first};
  end

  assign clearing_o = state_q == SClear;
  assign q_pop_o    = (state_q == SIdle) & q_valid_i & ~out_valid_q;

  // Sequencer of the back end.
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    clr_d       = clr_q;
    rel_idx_d   = rel_idx_q;
    rel_pend_d  = rel_pend_q;
    rel_addr_d  = rel_addr_q;
    rel_cnt_d   = rel_cnt_q;
    grp_d       = grp_q;
    used_d      = used_q;
    mem_we      = 1'b0;
    mem_wa      = cur_q.addr;
    mem_wd      = '0;
    mem_re      = 1'b0;
    mem_ra      = q_job_i.addr;
    out_valid_d = out_valid_q & out_stall_i;
    status_d    = status_q;
    chunk_d     = chunk_q;
    inner_d     = inner_q;
    level_d     = level_q;
    count_d     = count_q;

    case (state_q)
      SClear: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + 1'b1;
        if (clr_q == fcma_pkg::SlotAw'(fcma_pkg::TotalSlots - 1)) begin
          state_d = SIdle;
        end
      end

      SIdle: begin
        if (q_pop_o) begin
          cur_d = q_job_i;
          case (q_job_i.kind)
            fcma_pkg::KindTooLarge: begin
              out_valid_d = 1'b1;
              status_d    = fcma_pkg::StTooLarge;
              chunk_d     = '0;
              inner_d     = '0;
              level_d     = '0;
              count_d     = '0;
            end
            fcma_pkg::KindRelease: begin
              rel_idx_d  = '0;
              rel_pend_d = 1'b0;
              rel_cnt_d  = '0;
              state_d    = SRel;
            end
            default: begin
              mem_re  = 1'b1;
              state_d = SLook;
            end
          endcase
        end
      end

      SLook: begin
        inner_d = cur_q.inner;
        level_d = cur_q.level;
        chunk_d = '0;
        count_d = '0;
        if (rd_q[MemW-1]) begin
          out_valid_d = 1'b1;
          status_d    = fcma_pkg::StHit;
          chunk_d     = rd_q[fcma_pkg::ChunkW-1:0];
          state_d     = SIdle;
        end else if (cur_q.kind != fcma_pkg::KindWrite) begin
          out_valid_d = 1'b1;
          status_d    = fcma_pkg::StUnmapped;
          state_d     = SIdle;
        end else if (!(|grp_free)) begin
          out_valid_d = 1'b1;
          status_d    = fcma_pkg::StNoFree;
          inner_d     = '0;
          state_d     = SIdle;
        end else begin
          grp_d   = grp_first;
          state_d = SAlloc;
        end
      end

      SAlloc: begin
        used_d[new_chunk] = 1'b1;
        mem_we            = 1'b1;
        mem_wd            = {1'b1, new_chunk};
        out_valid_d       = 1'b1;
        status_d          = fcma_pkg::StAlloc;
        chunk_d           = new_chunk;
        state_d           = SIdle;
      end

      SRel: begin
        // Retire the slot read in the previous cycle.
        if (rel_pend_q) begin
          mem_we = 1'b1;
          mem_wa = rel_addr_q;
          if (rd_q[MemW-1]) begin
            used_d[rd_q[fcma_pkg::ChunkW-1:0]] = 1'b0;
            rel_cnt_d = rel_cnt_q + 1'b1;
          end
        end
        // Issue the next slot read, or finish once all are retired.
        if (rel_idx_q != fcma_pkg::LocalW'(fcma_pkg::SlotsPerFile)) begin
          mem_re     = 1'b1;
          mem_ra     = cur_q.addr + fcma_pkg::SlotAw'(rel_idx_q);
          rel_addr_d = mem_ra;
          rel_idx_d  = rel_idx_q + 1'b1;
          rel_pend_d = 1'b1;
        end else begin
          rel_pend_d = 1'b0;
          if (!rel_pend_q) begin
            out_valid_d = 1'b1;
            status_d    = fcma_pkg::StReleased;
            chunk_d     = '0;
            inner_d     = '0;
            level_d     = '0;
            count_d     = rel_cnt_q;
            state_d     = SIdle;
          end
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      rel_idx_q   <= '0;
      rel_pend_q  <= 1'b0;
      rel_cnt_q   <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rel_idx_q   <= rel_idx_d;
      rel_pend_q  <= rel_pend_d;
      rel_cnt_q   <= rel_cnt_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    rel_addr_q <= rel_addr_d;
    grp_q      <= grp_d;
    status_q   <= status_d;
    chunk_q    <= chunk_d;
    inner_q    <= inner_d;
    level_q    <= level_d;
    count_q    <= count_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign chunk_id_o        = chunk_q;
  assign offset_in_chunk_o = inner_q;
  assign map_level_o       = level_q;
  assign released_count_o  = count_q;

endmodule

[rtl/core/file_chunk_map_allocator.sv]
// ----------------------------------------------------------------------------
// file_chunk_map_allocator
// Maps a file byte offset to a physical chunk, allocating and releasing
// chunks from a shared bitmap.
// ----------------------------------------------------------------------------
// After reset the block clears its slot memory and takes no word until
// that pass is done. A read lookup reads the slot memory and then checks
// the slot; a write lookup that allocates goes through the memory read,
// the free-group search and the chunk pick; and a release walks all 92
// slots of the file through the slot memory port.
// A two-word queue lets new words be accepted while a result waits.
module file_chunk_map_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  file_index_i,
  input  logic [31:0] byte_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  chunk_id_o,
  output logic [11:0] offset_in_chunk_o,
  output logic [1:0]  map_level_o,
  output logic [6:0]  released_count_o
);

  logic           push, pop, q_full, q_valid, clearing;
  fcma_pkg::job_t push_job, pop_job;

  fcma_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .file_index_i  (file_index_i),
    .byte_offset_i (byte_offset_i),
    .hold_i        (q_full | clearing),
    .push_o        (push),
    .job_o         (push_job)
  );

  fcma_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .job_o      (pop_job)
  );

  fcma_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_job_i           (pop_job),
    .q_pop_o           (pop),
    .clearing_o        (clearing),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .chunk_id_o        (chunk_id_o),
    .offset_in_chunk_o (offset_in_chunk_o),
    .map_level_o       (map_level_o),
    .released_count_o  (released_count_o)
  );

endmodule
